### rtl/lld_pkg.sv
package lld_pkg;

	localparam int MAX_DEVICES = 8;
	localparam int LOAD_BITS   = 32;
	localparam int DEV_W       = 3;
	localparam int CNT_W       = 4;
	localparam int WEIGHT_W    = 20;
	localparam int OUT_LOAD_W  = 32;

	localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_CLAMP = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// item modes
	localparam logic MODE_ASSIGN  = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ALU_LT,
		ALU_ADD_SAT,
		ALU_SUB_CLAMP
	} lld_op_t;

	typedef struct packed {
		logic [LOAD_BITS-1:0] value;
		logic                 flag;
	} lld_alu_res_t;

	typedef struct packed {
		logic                 en;
		logic [DEV_W-1:0]     addr;
		logic [LOAD_BITS-1:0] data;
	} lld_wr_t;

endpackage

### rtl/lld_alu.sv
module lld_alu (
	input  lld_pkg::lld_op_t                op,
	input  logic [lld_pkg::LOAD_BITS-1:0]   a,
	input  logic [lld_pkg::LOAD_BITS-1:0]   b,
	output lld_pkg::lld_alu_res_t           res
);
	import lld_pkg::*;

	logic [LOAD_BITS:0] sum;
	logic [LOAD_BITS:0] diff;

	// one adder and one subtractor, result picked by the op
	assign sum  = {1'b0, a} + {1'b0, b};
	assign diff = {1'b0, a} - {1'b0, b};

	always_comb begin
		res = '0;
		case (op)
			ALU_LT: begin
				res.value = '0;
				res.flag  = diff[LOAD_BITS];
			end
			ALU_ADD_SAT: begin
				res.flag  = sum[LOAD_BITS];
				res.value = sum[LOAD_BITS] ? LOAD_MAX : sum[LOAD_BITS-1:0];
			end
			ALU_SUB_CLAMP: begin
				res.flag  = diff[LOAD_BITS];
				res.value = diff[LOAD_BITS] ? '0 : diff[LOAD_BITS-1:0];
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

### rtl/lld_load_file.sv
module lld_load_file (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [lld_pkg::DEV_W-1:0]       rd_addr,
	output logic [lld_pkg::LOAD_BITS-1:0]   rd_data,
	input  lld_pkg::lld_wr_t                wr
);
	import lld_pkg::*;

	logic [LOAD_BITS-1:0] load_q [MAX_DEVICES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DEVICES; i++) begin
				load_q[i] <= '0;
			end
		end else if (wr.en) begin
			load_q[wr.addr] <= wr.data;
		end
	end

	assign rd_data = load_q[rd_addr];

endmodule

### rtl/least_loaded_dispatcher_top.sv
// channel   direction  signals                              transaction when
// config    in         cfg_we, cfg_data[3:0]                cfg_we high at clk edge
// item      in         start, mode, weight, release_device  start high, busy low
// result    out        done, device, new_load, status       done high (one cycle)
//
// assign: one compare per active counter through the shared alu, then a step to close the scan,
// then one add in the update state; the active counters are the first effective device_count (1..8)
// release: a single subtract in the update state, with no scan
// a new item may be accepted in the cycle that done is high
// arst_n clears all load counters to zero and device_count to 1
// done cannot be stalled: the result is valid for that one cycle only
module least_loaded_dispatcher_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lld_pkg::CNT_W-1:0]        cfg_data,
	input  logic                             start,
	output logic                             busy,
	input  logic                             mode,
	input  logic [lld_pkg::WEIGHT_W-1:0]     weight,
	input  logic [lld_pkg::DEV_W-1:0]        release_device,
	output logic                             done,
	output logic [lld_pkg::DEV_W-1:0]        device,
	output logic [lld_pkg::OUT_LOAD_W-1:0]   new_load,
	output logic [1:0]                       status
);
	import lld_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      dev_count_q;
	logic [CNT_W-1:0]      n_eff;
	logic                  mode_q;
	logic [WEIGHT_W-1:0]   weight_q;
	logic [DEV_W-1:0]      dev_q;
	logic [CNT_W-1:0]      idx_q;
	logic [LOAD_BITS-1:0]  best_q;
	logic                  done_q;
	logic [DEV_W-1:0]      device_q;
	logic [LOAD_BITS-1:0]  new_load_q;
	logic [1:0]            status_q;

	logic [DEV_W-1:0]      rd_addr;
	logic [LOAD_BITS-1:0]  rd_data;
	lld_wr_t               wr;
	lld_op_t               alu_op;
	logic [LOAD_BITS-1:0]  alu_a;
	logic [LOAD_BITS-1:0]  alu_b;
	lld_alu_res_t          alu_res;
	logic                  rel_out_of_range;

	// device_count register, zero counts as one, large values cap at the maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_count_q <= CNT_W'(1);
		end else if (cfg_we) begin
			dev_count_q <= cfg_data;
		end
	end

	always_comb begin
		if (dev_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (dev_count_q > CNT_W'(MAX_DEVICES)) begin
			n_eff = CNT_W'(MAX_DEVICES);
		end else begin
			n_eff = dev_count_q;
		end
	end

	assign rel_out_of_range = ({1'b0, dev_q} >= n_eff);

	// scan walks the counters, update reads the chosen or named device
	assign rd_addr = (state_q == S_SCAN) ? idx_q[DEV_W-1:0] : dev_q;

	// shared alu: compare during scan, add or subtract in update
	always_comb begin
		alu_a = rd_data;
		if (state_q == S_SCAN) begin
			alu_op = ALU_LT;
			alu_b  = best_q;
		end else begin
			alu_op = (mode_q == MODE_ASSIGN) ? ALU_ADD_SAT : ALU_SUB_CLAMP;
			alu_b  = LOAD_BITS'(weight_q);
		end
	end

	lld_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	// counter write-back at the end of an in-range update
	always_comb begin
		wr.en   = (state_q == S_UPDATE) &&
			((mode_q == MODE_ASSIGN) || !rel_out_of_range);
		wr.addr = dev_q;
		wr.data = alu_res.value;
	end

	lld_load_file u_load_file (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr      (wr)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			done_q     <= 1'b0;
			mode_q     <= MODE_ASSIGN;
			weight_q   <= '0;
			dev_q      <= '0;
			idx_q      <= '0;
			best_q     <= '0;
			device_q   <= '0;
			new_load_q <= '0;
			status_q   <= ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q   <= mode;
						weight_q <= weight;
						idx_q    <= '0;
						// all-ones start value: device 0 wins unless a smaller load shows up
						best_q   <= LOAD_MAX;
						if (mode == MODE_ASSIGN) begin
							dev_q   <= '0;
							state_q <= S_SCAN;
						end else begin
							dev_q   <= release_device;
							state_q <= S_UPDATE;
						end
					end
				end
				S_SCAN: begin
					if (idx_q >= n_eff) begin
						state_q <= S_UPDATE;
					end else begin
						// strict less-than keeps ties on the lowest index
						if (alu_res.flag) begin
							best_q <= rd_data;
							dev_q  <= idx_q[DEV_W-1:0];
						end
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_UPDATE: begin
					done_q   <= 1'b1;
					device_q <= dev_q;
					if ((mode_q == MODE_RELEASE) && rel_out_of_range) begin
						new_load_q <= '0;
						status_q   <= ST_RANGE;
					end else begin
						new_load_q <= alu_res.value;
						status_q   <= alu_res.flag ? ST_CLAMP : ST_OK;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign device   = device_q;
	assign new_load = new_load_q[OUT_LOAD_W-1:0];
	assign status   = status_q;

	// result appears only after an update cycle
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_UPDATE))
		else $error("done without a preceding update");

	// an accepted transaction makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// out-of-range release reports a zero load
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_RANGE)) |-> (new_load == '0))
		else $error("out-of-range release with nonzero load");

	// only a release may report out of range
	a_range_release: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_RANGE)) |-> (mode_q == MODE_RELEASE))
		else $error("assign reported out of range");

	// counters never written while idle
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !wr.en)
		else $error("counter write while idle");

endmodule

### verif/least_loaded_dispatcher_top_tb.sv
module least_loaded_dispatcher_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lld_pkg::*;

	// run ends as failed if the stimulus has not finished by then
	localparam int CYCLE_LIMIT = 400_000;
	localparam int PHASE_ITEMS = 150;

	// tracks the load counters and holds the dispatch results still to come
	class load_tracker;
		typedef struct {
			logic [DEV_W-1:0]      dev;
			logic [OUT_LOAD_W-1:0] load;
			logic [1:0]            st;
		} dispatch_t;

		logic [LOAD_BITS-1:0] load [MAX_DEVICES];
		logic [CNT_W-1:0]     dev_count;
		dispatch_t            pending_dispatch [$];
		int                   mismatches;

		function new();
			foreach (load[i]) load[i] = '0;
			dev_count  = CNT_W'(1);
			mismatches = 0;
		endfunction

		function void set_count(logic [CNT_W-1:0] v);
			dev_count = v;
		endfunction

		function int pending_count();
			return pending_dispatch.size();
		endfunction

		// works out one dispatch transaction and updates the counters
		function dispatch_t predict_dispatch(logic m, logic [WEIGHT_W-1:0] w,
				logic [DEV_W-1:0] rdev);
			dispatch_t            r;
			int                   n;
			int                   i;
			logic [LOAD_BITS:0]   sum;
			n = (dev_count == 0) ? 1 :
				(dev_count > MAX_DEVICES) ? MAX_DEVICES : int'(dev_count);
			r.st = ST_OK;
			if (m == MODE_ASSIGN) begin
				r.dev = '0;
				for (i = 1; i < n; i++)
					if (load[i] < load[r.dev]) r.dev = DEV_W'(i);
				sum = {1'b0, load[r.dev]} + (LOAD_BITS+1)'(w);
				if (sum[LOAD_BITS]) begin
					load[r.dev] = LOAD_MAX;
					r.st = ST_CLAMP;
				end else begin
					load[r.dev] = sum[LOAD_BITS-1:0];
				end
				r.load = OUT_LOAD_W'(load[r.dev]);
			end else begin
				r.dev = rdev;
				if (int'(rdev) >= n) begin
					r.load = '0;
					r.st = ST_RANGE;
				end else if (LOAD_BITS'(w) > load[rdev]) begin
					load[rdev] = '0;
					r.load = '0;
					r.st = ST_CLAMP;
				end else begin
					load[rdev] = load[rdev] - LOAD_BITS'(w);
					r.load = OUT_LOAD_W'(load[rdev]);
				end
			end
			pending_dispatch.insert(pending_dispatch.size(), r);
			return r;
		endfunction

		function void compare_dispatch(logic [DEV_W-1:0] dev, logic [OUT_LOAD_W-1:0] nl,
				logic [1:0] st);
			dispatch_t e;
			if (pending_dispatch.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with none pending: device %0d load %0d status %0d",
						$time, dev, nl, st);
				return;
			end
			e = pending_dispatch.pop_front();
			if (dev !== e.dev || nl !== e.load || st !== e.st) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: mismatch: expected device %0d load %0d status %0d, ",
						"got device %0d load %0d status %0d"},
						$time, e.dev, e.load, e.st, dev, nl, st);
			end
		endfunction
	endclass

	// a task handed out and not yet released, kept so releases can be well formed
	typedef struct {
		logic [DEV_W-1:0]    dev;
		logic [WEIGHT_W-1:0] w;
	} open_task_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CNT_W-1:0]      cfg_data = '0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  mode = MODE_ASSIGN;
	logic [WEIGHT_W-1:0]   weight = '0;
	logic [DEV_W-1:0]      release_device = '0;
	logic                  done;
	logic [DEV_W-1:0]      device;
	logic [OUT_LOAD_W-1:0] new_load;
	logic [1:0]            status;

	load_tracker tracker = new();
	open_task_t  open_tasks [$];
	int          cycle_count = 0;

	least_loaded_dispatcher_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.weight         (weight),
		.release_device (release_device),
		.done           (done),
		.device         (device),
		.new_load       (new_load),
		.status         (status)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result side: done is a one-cycle strobe, the receiver has no way to stall it
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && done)
			tracker.compare_dispatch(device, new_load, status);
	end

	// watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// one transaction on the item channel; start stays high after acceptance so that
	// a zero gap gives back-to-back items, and is lowered only before an idle gap or a drain
	task automatic send_item(input logic m, input logic [WEIGHT_W-1:0] w,
			input logic [DEV_W-1:0] rdev, input int gap);
		load_tracker::dispatch_t r;
		open_task_t              ot;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start          <= 1'b1;
		mode           <= m;
		weight         <= w;
		release_device <= rdev;
		do @(posedge clk); while (busy);
		// accepted at this edge
		r = tracker.predict_dispatch(m, w, rdev);
		if (m == MODE_ASSIGN) begin
			ot.dev = r.dev;
			ot.w   = w;
			open_tasks.insert(open_tasks.size(), ot);
			if (open_tasks.size() > 64) void'(open_tasks.pop_front());
		end
	endtask

	// sender holds off until every outstanding result has come back
	task automatic drain_results();
		start <= 1'b0;
		while (tracker.pending_count() != 0) @(posedge clk);
	endtask

	// device_count is only written while the block is idle
	task automatic write_count(input logic [CNT_W-1:0] v);
		drain_results();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		tracker.set_count(v);
		cfg_we <= 1'b0;
	endtask

	// zero, all ones, small values and the full range
	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2, 3: return WEIGHT_W'($urandom_range(0, 255));
			default: return WEIGHT_W'($urandom_range(0, (1 << WEIGHT_W) - 1));
		endcase
	endfunction

	// half assigns; most releases give back a task that was really handed out,
	// the rest use random devices and weights (clamps and out-of-range devices)
	task automatic random_item(input int gap);
		int         pick;
		int         k;
		open_task_t t;
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			send_item(MODE_ASSIGN, pick_weight(), DEV_W'($urandom), gap);
		end else if (pick < 8 && open_tasks.size() != 0) begin
			k = $urandom_range(0, open_tasks.size() - 1);
			t = open_tasks[k];
			open_tasks.delete(k);
			send_item(MODE_RELEASE, t.w, t.dev, gap);
		end else if (pick == 9) begin
			send_item(MODE_RELEASE, WEIGHT_W'($urandom_range(0, 255)), DEV_W'($urandom), gap);
		end else begin
			send_item(MODE_RELEASE, pick_weight(), DEV_W'($urandom), gap);
		end
	endtask

	initial begin
		logic [CNT_W-1:0]     phase_counts [12];
		logic [LOAD_BITS-1:0] headroom;
		int                   full_steps;
		int                   gap_max;

		// extremes first, then the rest of the range including the saturating values
		phase_counts = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd4, 4'd2, 4'd6, 4'd9, 4'd3, 4'd5,
			4'd7, 4'd12};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// count of zero acts as a single device
		write_count(4'd0);
		send_item(MODE_ASSIGN, '0, 3'd5, 0);
		send_item(MODE_ASSIGN, '1, 3'd0, 0);
		send_item(MODE_RELEASE, '0, 3'd0, 0);
		// devices past the active count are rejected with no state change
		send_item(MODE_RELEASE, 20'd1, 3'd1, 0);
		send_item(MODE_RELEASE, 20'd1, 3'd7, 2);
		// release down to exactly zero, then one more clamps
		send_item(MODE_RELEASE, '1, 3'd0, 0);
		send_item(MODE_RELEASE, 20'd1, 3'd0, 0);

		// count above the maximum saturates to all eight devices
		write_count(4'd15);
		// all counters equal: ties go to the lowest index, one device after another
		repeat (8) send_item(MODE_ASSIGN, 20'd5, 3'd0, 0);
		send_item(MODE_RELEASE, 20'd3, 3'd7, 1);
		send_item(MODE_ASSIGN, '0, 3'd0, 0);
		send_item(MODE_RELEASE, 20'd100, 3'd3, 0);
		send_item(MODE_ASSIGN, 20'h80000, 3'd7, 3);

		// weights of the directed tasks no longer match after the clamps
		open_tasks.delete();

		// --- random part, one phase per device_count setting ---
		for (int p = 0; p < 12; p++) begin
			write_count(phase_counts[p]);
			// some phases run back to back with no idle gaps between items, apart from the drains
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ((p == 1 && i == PHASE_ITEMS / 2) || $urandom_range(0, 99) == 0)
					drain_results();
				random_item($urandom_range(0, gap_max));
			end
		end

		// --- counter saturation on device 0 ---
		// with one device every assign lands on device 0; fill it up to exactly the top
		write_count(4'd1);
		headroom   = LOAD_MAX - tracker.load[0];
		full_steps = int'(headroom / LOAD_BITS'({WEIGHT_W{1'b1}}));
		for (int i = 0; i < full_steps; i++)
			send_item(MODE_ASSIGN, '1, DEV_W'($urandom),
				($urandom_range(0, 15) == 0) ? $urandom_range(1, 15) : 0);
		// lands exactly on the maximum without saturating
		send_item(MODE_ASSIGN, WEIGHT_W'(headroom % LOAD_BITS'({WEIGHT_W{1'b1}})), 3'd0, 0);
		// anything more saturates
		send_item(MODE_ASSIGN, 20'd1, 3'd0, 0);
		send_item(MODE_ASSIGN, '1, 3'd0, 1);
		send_item(MODE_RELEASE, 20'd5, 3'd0, 0);
		send_item(MODE_ASSIGN, 20'd20, 3'd0, 0);
		send_item(MODE_RELEASE, '1, 3'd0, 0);
		send_item(MODE_RELEASE, 20'd9, 3'd4, 2);

		// wait for the last results, then keep watching for any stray strobe
		drain_results();
		repeat (12) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_count() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### sim.f
rtl/lld_pkg.sv
rtl/lld_alu.sv
rtl/lld_load_file.sv
rtl/least_loaded_dispatcher_top.sv
verif/least_loaded_dispatcher_top_tb.sv
